>>> rtl/core/twlm_pkg.sv
package twlm_pkg;

  // Table geometry
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned PTR_W         = IDX_W + 1;
  localparam int unsigned AGE_W         = IDX_W;

  // Field widths
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned CPU_W  = 8;
  localparam int unsigned GRP_W  = 23;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Event kinds
  localparam logic [1:0] KIND_WAKE   = 2'd0;
  localparam logic [1:0] KIND_EXIT   = 2'd1;
  localparam logic [1:0] KIND_SWITCH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GROUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LATENCY  = 2'd2;

  typedef enum logic [2:0] {
    STATUS_IGNORED   = 3'd0,
    STATUS_STORED    = 3'd1,
    STATUS_EXIT      = 3'd2,
    STATUS_UNMATCHED = 3'd3,
    STATUS_FILTERED  = 3'd4,
    STATUS_REPORTED  = 3'd5,
    STATUS_DROPPED   = 3'd6
  } status_e;

  typedef enum logic {
    TBL_STORE,
    TBL_DELETE
  } tbl_op_e;

  typedef enum logic [1:0] {
    STAT_NONE,
    STAT_WAKE,
    STAT_UNMATCH,
    STAT_MATCH
  } stat_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TABLE,
    ST_UPD,
    ST_RESP
  } top_state_e;

  typedef enum logic [1:0] {
    TB_IDLE,
    TB_SCAN,
    TB_FIX,
    TB_DONE
  } tbl_state_e;

  // One stored wakeup record
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    logic [CPU_W-1:0]  cpu;
    logic [AGE_W-1:0]  age;
  } rec_t;

  typedef struct packed {
    logic              start;
    tbl_op_e           op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    logic [CPU_W-1:0]  cpu;
  } tbl_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [TIME_W-1:0] stamp;
    logic [CPU_W-1:0]  cpu;
  } tbl_rsp_t;

endpackage

>>> rtl/core/twlm_ram.sv
module twlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/twlm_table.sv
module twlm_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  twlm_pkg::tbl_req_t  req_i,
  output twlm_pkg::tbl_rsp_t  rsp_o
);
  import twlm_pkg::*;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(TABLE_ENTRIES - 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(TABLE_ENTRIES);

  tbl_state_e state_q, state_d;

  // Transaction being worked on
  tbl_op_e           op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [TIME_W-1:0] stamp_q, stamp_d;
  logic [CPU_W-1:0]  cpu_q, cpu_d;

  // Sweep pointer and the entry whose read data arrives this cycle
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  // Scan results
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [AGE_W-1:0]  hit_age_q, hit_age_d;
  logic [TIME_W-1:0] hit_stamp_q, hit_stamp_d;
  logic [CPU_W-1:0]  hit_cpu_q, hit_cpu_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic [IDX_W-1:0]  old_idx_q, old_idx_d;

  // Memory port signals
  logic             issue;
  logic             we;
  logic [IDX_W-1:0] waddr;
  rec_t             wdata;
  rec_t             rdata;

  // Slot chosen for the update pass
  logic             rm;
  logic [IDX_W-1:0] slot;
  logic [AGE_W-1:0] slot_age;
  logic             cur_valid;
  logic             inc;
  logic             dec;

  twlm_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // Slot selection from the scan results: a matching key first, then the
  // first free entry, then the entry inserted longest ago.
  assign rm       = hit_q || (op_q == TBL_STORE && !free_q);
  assign slot     = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
  assign slot_age = hit_q ? hit_age_q : AGE_MAX;

  assign issue     = (state_q == TB_SCAN || state_q == TB_FIX) && (ptr_q < PTR_END);
  assign cur_valid = valid_q[chk_idx_q];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      TB_IDLE: begin
        if (req_i.start) begin
          state_d = TB_SCAN;
        end
      end
      TB_SCAN: begin
        if (ptr_q == PTR_END) begin
          if (op_q == TBL_DELETE && !hit_d) begin
            state_d = TB_DONE;
          end else begin
            state_d = TB_FIX;
          end
        end
      end
      TB_FIX: begin
        if (ptr_q == PTR_END) begin
          state_d = TB_DONE;
        end
      end
      TB_DONE: begin
        state_d = TB_IDLE;
      end
      default: begin
        state_d = TB_IDLE;
      end
    endcase
  end

  // Sweep datapath: search on the first pass, age update and write on the second
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    stamp_d     = stamp_q;
    cpu_d       = cpu_q;
    ptr_d       = issue ? ptr_q + 1'b1 : ptr_q;
    chk_vld_d   = issue;
    chk_idx_d   = ptr_q[IDX_W-1:0];
    valid_d     = valid_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_age_d   = hit_age_q;
    hit_stamp_d = hit_stamp_q;
    hit_cpu_d   = hit_cpu_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    we          = 1'b0;
    waddr       = chk_idx_q;
    wdata       = rdata;
    inc         = 1'b0;
    dec         = 1'b0;
    case (state_q)
      TB_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          key_d   = req_i.key;
          stamp_d = req_i.stamp;
          cpu_d   = req_i.cpu;
          ptr_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      TB_SCAN: begin
        if (chk_vld_q) begin
          if (cur_valid && rdata.key == key_q) begin
            hit_d       = 1'b1;
            hit_idx_d   = chk_idx_q;
            hit_age_d   = rdata.age;
            hit_stamp_d = rdata.stamp;
            hit_cpu_d   = rdata.cpu;
          end
          if (!cur_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (cur_valid && rdata.age == AGE_MAX) begin
            old_idx_d = chk_idx_q;
          end
        end
        if (ptr_q == PTR_END) begin
          ptr_d = '0;
        end
      end
      TB_FIX: begin
        if (chk_vld_q) begin
          if (chk_idx_q == slot) begin
            if (op_q == TBL_STORE) begin
              we          = 1'b1;
              wdata.key   = key_q;
              wdata.stamp = stamp_q;
              wdata.cpu   = cpu_q;
              wdata.age   = '0;
              valid_d[chk_idx_q] = 1'b1;
            end else begin
              valid_d[chk_idx_q] = 1'b0;
            end
          end else if (cur_valid) begin
            // Close the gap left by the removed entry, then age for the insert.
            inc       = (op_q == TBL_STORE);
            dec       = rm && (rdata.age > slot_age);
            we        = 1'b1;
            wdata.age = rdata.age + AGE_W'(inc) - AGE_W'(dec);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= TB_IDLE;
      ptr_q     <= '0;
      chk_vld_q <= 1'b0;
      valid_q   <= '0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      op_q      <= TBL_STORE;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      chk_vld_q <= chk_vld_d;
      valid_q   <= valid_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      op_q      <= op_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    stamp_q     <= stamp_d;
    cpu_q       <= cpu_d;
    chk_idx_q   <= chk_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_age_q   <= hit_age_d;
    hit_stamp_q <= hit_stamp_d;
    hit_cpu_q   <= hit_cpu_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
  end

  assign rsp_o.done  = (state_q == TB_DONE);
  assign rsp_o.found = hit_q;
  assign rsp_o.stamp = hit_stamp_q;
  assign rsp_o.cpu   = hit_cpu_q;

endmodule

>>> rtl/core/twlm_stats.sv
module twlm_stats (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          calc_i,
  input  logic [twlm_pkg::TIME_W-1:0]   now_i,
  input  logic [twlm_pkg::TIME_W-1:0]   stamp_i,
  input  twlm_pkg::stat_op_e            op_i,
  input  logic [twlm_pkg::CNT_W-1:0]    min_latency_i,
  input  logic                          sink_full_i,
  input  logic [twlm_pkg::GRP_W-1:0]    prev_thread_i,
  input  logic [twlm_pkg::GRP_W-1:0]    next_thread_i,
  output twlm_pkg::status_e             match_status_o,
  output logic [twlm_pkg::CNT_W-1:0]    latency_o,
  output logic [twlm_pkg::CNT_W-1:0]    wakeup_count_o,
  output logic [twlm_pkg::CNT_W-1:0]    unmatched_count_o,
  output logic [twlm_pkg::CNT_W-1:0]    filtered_count_o,
  output logic [twlm_pkg::CNT_W-1:0]    dropped_count_o,
  output logic [twlm_pkg::CNT_W-1:0]    report_count_o,
  output logic [twlm_pkg::CNT_W-1:0]    latency_total_o,
  output logic [twlm_pkg::CNT_W-1:0]    latency_max_o,
  output logic [twlm_pkg::GRP_W-1:0]    max_prev_thread_o,
  output logic [twlm_pkg::GRP_W-1:0]    max_next_thread_o
);
  import twlm_pkg::*;

  logic [CNT_W-1:0] lat_q;
  logic [CNT_W-1:0] wake_q, unm_q, filt_q, drop_q, rep_q, total_q, max_q;
  logic [GRP_W-1:0] max_prev_q, max_next_q;
  status_e          cls;
  logic             new_max;

  // Latency is taken modulo 2^64 when the matching record comes back.
  always_ff @(posedge clk_i) begin
    if (calc_i) begin
      lat_q <= now_i - stamp_i;
    end
  end

  // Classify a matched switch
  always_comb begin
    if (min_latency_i != '0 && lat_q < min_latency_i) begin
      cls = STATUS_FILTERED;
    end else if (sink_full_i) begin
      cls = STATUS_DROPPED;
    end else begin
      cls = STATUS_REPORTED;
    end
  end

  assign new_max = (lat_q > max_q);

  // Statistics update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_q     <= '0;
      unm_q      <= '0;
      filt_q     <= '0;
      drop_q     <= '0;
      rep_q      <= '0;
      total_q    <= '0;
      max_q      <= '0;
      max_prev_q <= '0;
      max_next_q <= '0;
    end else begin
      case (op_i)
        STAT_WAKE: begin
          wake_q <= wake_q + 1'b1;
        end
        STAT_UNMATCH: begin
          unm_q <= unm_q + 1'b1;
        end
        STAT_MATCH: begin
          case (cls)
            STATUS_FILTERED: filt_q <= filt_q + 1'b1;
            STATUS_DROPPED:  drop_q <= drop_q + 1'b1;
            default: begin
              rep_q   <= rep_q + 1'b1;
              total_q <= total_q + lat_q;
              if (new_max) begin
                max_q      <= lat_q;
                max_prev_q <= prev_thread_i;
                max_next_q <= next_thread_i;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign match_status_o    = cls;
  assign latency_o         = lat_q;
  assign wakeup_count_o    = wake_q;
  assign unmatched_count_o = unm_q;
  assign filtered_count_o  = filt_q;
  assign dropped_count_o   = drop_q;
  assign report_count_o    = rep_q;
  assign latency_total_o   = total_q;
  assign latency_max_o     = max_q;
  assign max_prev_thread_o = max_prev_q;
  assign max_next_thread_o = max_next_q;

endmodule

>>> rtl/core/tagged_wakeup_latency_monitor_core.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// event in | start_i, busy_o     | kind_i, task_key_i, now_time_i, cpu_id_i,
//          |                     | group_id_i, next_thread_i, prev_thread_i,
//          |                     | sink_full_i
// result   | done_o (one cycle)  | status_o, latency_o, wake_cpu_o, counters,
//          |                     | latency_max_o, max_*_thread_o
// config   | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
// An event is taken when start_i is high and busy_o is low. A stored wakeup, or an exit or switch
// that finds its key, sweeps the table twice (search, then age update and write) through the
// memory's one read port; a matched switch then passes through an update state. An exit or switch
// whose key is absent stops after the search; ignored events skip the table. The result is shown
// for one cycle under done_o; the receiver cannot stall it. Reset clears valid bits, statistics
// and configuration.
module tagged_wakeup_latency_monitor_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        kind_i,
  input  logic [twlm_pkg::KEY_W-1:0]        task_key_i,
  input  logic [twlm_pkg::TIME_W-1:0]       now_time_i,
  input  logic [twlm_pkg::CPU_W-1:0]        cpu_id_i,
  input  logic [twlm_pkg::GRP_W-1:0]        group_id_i,
  input  logic [twlm_pkg::GRP_W-1:0]        next_thread_i,
  input  logic [twlm_pkg::GRP_W-1:0]        prev_thread_i,
  input  logic                              sink_full_i,
  input  logic                              cfg_we_i,
  input  logic [twlm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [twlm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                              done_o,
  output logic [2:0]                        status_o,
  output logic [twlm_pkg::CNT_W-1:0]        latency_o,
  output logic [twlm_pkg::CPU_W-1:0]        wake_cpu_o,
  output logic [twlm_pkg::CNT_W-1:0]        wakeup_count_o,
  output logic [twlm_pkg::CNT_W-1:0]        unmatched_count_o,
  output logic [twlm_pkg::CNT_W-1:0]        filtered_count_o,
  output logic [twlm_pkg::CNT_W-1:0]        dropped_count_o,
  output logic [twlm_pkg::CNT_W-1:0]        report_count_o,
  output logic [twlm_pkg::CNT_W-1:0]        latency_total_o,
  output logic [twlm_pkg::CNT_W-1:0]        latency_max_o,
  output logic [twlm_pkg::GRP_W-1:0]        max_prev_thread_o,
  output logic [twlm_pkg::GRP_W-1:0]        max_next_thread_o
);
  import twlm_pkg::*;

  top_state_e state_q, state_d;

  // Configuration
  logic             enable_q;
  logic [GRP_W-1:0] target_q;
  logic [CNT_W-1:0] min_lat_q;

  // Transaction context
  logic [1:0]        kind_q;
  logic [TIME_W-1:0] now_q;
  logic [GRP_W-1:0]  nthr_q, pthr_q;
  logic              full_q;

  // Result registers
  status_e          status_q, status_d;
  logic             match_q, match_d;
  logic [CPU_W-1:0] wake_cpu_q, wake_cpu_d;

  logic     accept;
  logic     grp_ok, wake_pass, switch_pass, table_go;
  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;
  stat_op_e stat_op;
  logic     calc;
  status_e  match_status;
  logic [CNT_W-1:0] lat;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // Admission filters, evaluated at the accepting edge
  assign grp_ok      = (group_id_i != '0) && (target_q == '0 || group_id_i == target_q);
  assign wake_pass   = (kind_i == KIND_WAKE) && enable_q && grp_ok;
  assign switch_pass = (kind_i == KIND_SWITCH) && enable_q && grp_ok && (next_thread_i != '0);
  assign table_go    = wake_pass || switch_pass || (kind_i == KIND_EXIT);

  twlm_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  twlm_stats u_stats (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .calc_i            (calc),
    .now_i             (now_q),
    .stamp_i           (tbl_rsp.stamp),
    .op_i              (stat_op),
    .min_latency_i     (min_lat_q),
    .sink_full_i       (full_q),
    .prev_thread_i     (pthr_q),
    .next_thread_i     (nthr_q),
    .match_status_o    (match_status),
    .latency_o         (lat),
    .wakeup_count_o    (wakeup_count_o),
    .unmatched_count_o (unmatched_count_o),
    .filtered_count_o  (filtered_count_o),
    .dropped_count_o   (dropped_count_o),
    .report_count_o    (report_count_o),
    .latency_total_o   (latency_total_o),
    .latency_max_o     (latency_max_o),
    .max_prev_thread_o (max_prev_thread_o),
    .max_next_thread_o (max_next_thread_o)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = table_go ? ST_TABLE : ST_RESP;
        end
      end
      ST_TABLE: begin
        if (tbl_rsp.done) begin
          if (kind_q == KIND_SWITCH && tbl_rsp.found) begin
            state_d = ST_UPD;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_UPD: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    tbl_req.start = 1'b0;
    tbl_req.op    = TBL_DELETE;
    tbl_req.key   = task_key_i;
    tbl_req.stamp = now_time_i;
    tbl_req.cpu   = cpu_id_i;
    stat_op       = STAT_NONE;
    calc          = 1'b0;
    status_d      = status_q;
    match_d       = match_q;
    wake_cpu_d    = wake_cpu_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d      = STATUS_IGNORED;
          match_d       = 1'b0;
          wake_cpu_d    = '0;
          tbl_req.start = table_go;
          tbl_req.op    = wake_pass ? TBL_STORE : TBL_DELETE;
        end
      end
      ST_TABLE: begin
        if (tbl_rsp.done) begin
          case (kind_q)
            KIND_WAKE: begin
              stat_op  = STAT_WAKE;
              status_d = STATUS_STORED;
            end
            KIND_EXIT: begin
              status_d = STATUS_EXIT;
            end
            KIND_SWITCH: begin
              if (tbl_rsp.found) begin
                calc       = 1'b1;
                match_d    = 1'b1;
                wake_cpu_d = tbl_rsp.cpu;
              end else begin
                stat_op  = STAT_UNMATCH;
                status_d = STATUS_UNMATCHED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_UPD: begin
        stat_op  = STAT_MATCH;
        status_d = match_status;
      end
      default: begin
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      enable_q  <= 1'b0;
      target_q  <= '0;
      min_lat_q <= '0;
      status_q  <= STATUS_IGNORED;
      match_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      match_q  <= match_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE:       enable_q  <= cfg_wdata_i[0];
          CFG_TARGET_GROUP: target_q  <= cfg_wdata_i[GRP_W-1:0];
          CFG_MIN_LATENCY:  min_lat_q <= cfg_wdata_i[CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Transaction context captured on accept
  always_ff @(posedge clk_i) begin
    wake_cpu_q <= wake_cpu_d;
    if (accept) begin
      kind_q <= kind_i;
      now_q  <= now_time_i;
      nthr_q <= next_thread_i;
      pthr_q <= prev_thread_i;
      full_q <= sink_full_i;
    end
  end

  assign done_o     = (state_q == ST_RESP);
  assign status_o   = status_q;
  assign latency_o  = match_q ? lat : '0;
  assign wake_cpu_o = wake_cpu_q;

endmodule
